// ----- design/ufe_pkg.sv -----
package ufe_pkg;

  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int RANK_W  = 4;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 2;

  localparam int MAX_NODES_DEF = 1024;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [RANK_W-1:0]  RANK_RESET  = 4'd1;
  localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

  // Operation codes carried in the input beat.
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNION = 2'd2;

  // What the result beat reports.
  localparam logic [KIND_W-1:0] KIND_ZERO  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNION = 2'd3;

  typedef struct packed {
    logic              capture;
    logic              sweep;
    logic              walk_start;
    logic              walk_up;
    logic              root_found;
    logic              compress;
    logic              link;
    logic              bump;
    logic              post;
    logic              sel_b;
    logic [KIND_W-1:0] kind;
  } ufe_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic at_root;
    logic comp_done;
    logic same_root;
    logic rank_tie;
    logic sweep_last;
    logic out_free;
  } ufe_stat_t;

endpackage

// ----- design/union_find_engine.sv -----
// Channel  Direction  Beat contents
// in_      slave      tdata: mode[1:0], node_a[11:2], node_b[21:12]
// out_     master     tdata: root[9:0], merged[10], bad_node[11]
// cfg_     write      wr_data: node_count[10:0]
//
// A find walks the path from node_a up to its root and then compresses it; a union does the
// same for node_a and node_b, then links two distinct sets and bumps a rank on a tie.
// Each walk step is one table read, so the path lengths set how long an operation takes.
// Clear writes the whole table, one entry per cycle.
// After reset a clearing pass over all MAX_NODES entries runs before in_tready rises.
// A waiting result does not block the next input beat; only the next result waits for it.
module union_find_engine #(
  parameter int MAX_NODES = ufe_pkg::MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode, node_a, node_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // root, merged, bad_node
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);

  ufe_pkg::ufe_cmd_t          cmd;
  ufe_pkg::ufe_stat_t         stat;
  logic [ufe_pkg::MODE_W-1:0] in_mode;
  logic [ufe_pkg::NODE_W-1:0] in_node_a, in_node_b, out_root;
  logic                       out_merged, out_bad;

  assign in_mode   = in_tdata[1:0];
  assign in_node_a = in_tdata[11:2];
  assign in_node_b = in_tdata[21:12];
  assign out_tdata = {4'd0, out_bad, out_merged, out_root};

  ufe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_mode),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ufe_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mode     (in_mode),
    .in_node_a   (in_node_a),
    .in_node_b   (in_node_b),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_root    (out_root),
    .out_merged  (out_merged),
    .out_bad     (out_bad)
  );

endmodule

// ----- design/ufe_ctrl.sv -----
module ufe_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [ufe_pkg::MODE_W-1:0] in_mode,
  output logic                       in_ready,
  input  ufe_pkg::ufe_stat_t         stat,
  output ufe_pkg::ufe_cmd_t          cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_COMP  = 4'd5;
  localparam logic [3:0] S_LINK  = 4'd6;
  localparam logic [3:0] S_BUMP  = 4'd7;
  localparam logic [3:0] S_POST  = 4'd8;

  logic [3:0]                 state_r, state_nxt;
  logic                       phase_b_r, phase_b_nxt;
  logic [ufe_pkg::KIND_W-1:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt   = state_r;
    phase_b_nxt = phase_b_r;
    kind_nxt    = kind_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.sel_b   = phase_b_r;
    cmd.kind    = kind_r;
    case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          phase_b_nxt = 1'b0;
          case (in_mode)
            ufe_pkg::MODE_CLEAR: begin
              kind_nxt  = ufe_pkg::KIND_ZERO;
              state_nxt = S_CLEAR;
            end
            ufe_pkg::MODE_FIND, ufe_pkg::MODE_UNION: begin
              if (stat.in_bad) begin
                kind_nxt  = ufe_pkg::KIND_BAD;
                state_nxt = S_POST;
              end else begin
                kind_nxt  = (in_mode == ufe_pkg::MODE_FIND) ? ufe_pkg::KIND_FIND
                                                            : ufe_pkg::KIND_UNION;
                state_nxt = S_START;
              end
            end
            default: begin
              kind_nxt  = ufe_pkg::KIND_ZERO;
              state_nxt = S_POST;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_POST;
        end
      end
      S_START: begin
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        if (stat.at_root) begin
          cmd.root_found = 1'b1;
          state_nxt      = S_COMP;
        end else begin
          cmd.walk_up = 1'b1;
        end
      end
      S_COMP: begin
        if (!stat.comp_done) begin
          cmd.compress = 1'b1;
        end else if (kind_r == ufe_pkg::KIND_FIND) begin
          state_nxt = S_POST;
        end else if (!phase_b_r) begin
          phase_b_nxt = 1'b1;
          state_nxt   = S_START;
        end else if (stat.same_root) begin
          state_nxt = S_POST;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = stat.rank_tie ? S_BUMP : S_POST;
      end
      S_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (stat.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      phase_b_r <= 1'b0;
      kind_r    <= ufe_pkg::KIND_ZERO;
    end else begin
      state_r   <= state_nxt;
      phase_b_r <= phase_b_nxt;
      kind_r    <= kind_nxt;
    end
  end

endmodule

// ----- design/ufe_dp.sv -----
module ufe_dp #(
  parameter int MAX_NODES = ufe_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ufe_pkg::MODE_W-1:0]  in_mode,
  input  logic [ufe_pkg::NODE_W-1:0]  in_node_a,
  input  logic [ufe_pkg::NODE_W-1:0]  in_node_b,
  input  logic                        cfg_wr_en,
  input  logic [ufe_pkg::COUNT_W-1:0] cfg_wr_data,
  input  ufe_pkg::ufe_cmd_t           cmd,
  output ufe_pkg::ufe_stat_t          stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ufe_pkg::NODE_W-1:0]  out_root,
  output logic                        out_merged,
  output logic                        out_bad
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = ufe_pkg::RANK_W + AW;
  localparam int CW = 17;
  localparam logic [AW-1:0] LAST  = AW'(MAX_NODES - 1);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_NODES);

  // Each entry holds {rank, parent}.
  logic [EW-1:0] mem [MAX_NODES];
  logic [EW-1:0] rdata_r;

  logic [AW-1:0]                count_pad;
  logic [ufe_pkg::COUNT_W-1:0]  count_r;
  logic [AW-1:0]                cnt_r;
  logic [AW-1:0]                node_a_r, node_b_r, cur_r, start_r;
  logic [AW-1:0]                root_a_r, root_b_r;
  logic [ufe_pkg::RANK_W-1:0]   rank_a_r, rank_b_r, rank_inc;
  logic                         out_valid_r;
  logic [ufe_pkg::NODE_W-1:0]   out_root_r;
  logic                         out_merged_r, out_bad_r;

  logic [CW-1:0]                a_ext, b_ext, count_ext;
  logic                         a_ok, b_ok, a_gt;
  logic [AW-1:0]                rd_par, cur_root, node_sel, res_root;
  logic [ufe_pkg::RANK_W-1:0]   rd_rank;
  logic [31:0]                  res_root_w;
  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [EW-1:0]                wr_data;

  assign count_pad = '0;
  assign a_ext     = CW'(in_node_a);
  assign b_ext     = CW'(in_node_b);
  assign count_ext = CW'(count_r);
  assign a_ok      = (a_ext < count_ext) && (a_ext < LIMIT);
  assign b_ok      = (b_ext < count_ext) && (b_ext < LIMIT);

  assign rd_par   = rdata_r[AW-1:0];
  assign rd_rank  = rdata_r[EW-1:AW];
  assign cur_root = cmd.sel_b ? root_b_r : root_a_r;
  assign node_sel = cmd.sel_b ? node_b_r : node_a_r;
  assign a_gt     = rank_a_r > rank_b_r;
  assign rank_inc = (rank_b_r == ufe_pkg::RANK_MAX) ? rank_b_r : rank_b_r + 1'b1;

  always_comb begin
    stat.in_bad     = (in_mode == ufe_pkg::MODE_UNION) ? !(a_ok && b_ok) : !a_ok;
    stat.at_root    = rd_par == cur_r;
    stat.comp_done  = cur_r == cur_root;
    stat.same_root  = root_a_r == root_b_r;
    stat.rank_tie   = rank_a_r == rank_b_r;
    stat.sweep_last = cnt_r == LAST;
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = {ufe_pkg::RANK_RESET, cnt_r};
    rd_en   = 1'b0;
    rd_addr = cur_r;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end
    if (cmd.walk_start) begin
      rd_en   = 1'b1;
      rd_addr = node_sel;
    end
    if (cmd.walk_up) begin
      rd_en   = 1'b1;
      rd_addr = rd_par;
    end
    if (cmd.root_found) begin
      rd_en   = 1'b1;
      rd_addr = start_r;
    end
    if (cmd.compress) begin
      // Point the current node at the root and fetch its old parent.
      wr_en   = 1'b1;
      wr_addr = cur_r;
      wr_data = {rd_rank, cur_root};
      rd_en   = 1'b1;
      rd_addr = rd_par;
    end
    if (cmd.link) begin
      wr_en = 1'b1;
      if (a_gt) begin
        wr_addr = root_b_r;
        wr_data = {rank_b_r, root_a_r};
      end else begin
        wr_addr = root_a_r;
        wr_data = {rank_a_r, root_b_r};
      end
    end
    if (cmd.bump) begin
      wr_en   = 1'b1;
      wr_addr = root_b_r;
      wr_data = {rank_inc, root_b_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node_a_r <= a_ext[AW-1:0];
      node_b_r <= b_ext[AW-1:0];
    end
    if (cmd.walk_start) begin
      cur_r   <= node_sel;
      start_r <= node_sel;
    end
    if (cmd.walk_up || cmd.compress) begin
      cur_r <= rd_par;
    end
    if (cmd.root_found) begin
      cur_r <= start_r;
      if (cmd.sel_b) begin
        root_b_r <= cur_r;
        rank_b_r <= rd_rank;
      end else begin
        root_a_r <= cur_r;
        rank_a_r <= rd_rank;
      end
    end
  end

  always_comb begin
    if (cmd.kind == ufe_pkg::KIND_UNION) begin
      res_root = (stat.same_root || a_gt) ? root_a_r : root_b_r;
    end else if (cmd.kind == ufe_pkg::KIND_FIND) begin
      res_root = root_a_r;
    end else begin
      res_root = count_pad;
    end
  end

  assign res_root_w = 32'(res_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= ufe_pkg::COUNT_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (cmd.sweep) begin
        cnt_r <= stat.sweep_last ? '0 : cnt_r + 1'b1;
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_root_r   <= res_root_w[ufe_pkg::NODE_W-1:0];
      out_merged_r <= (cmd.kind == ufe_pkg::KIND_UNION) && !stat.same_root;
      out_bad_r    <= cmd.kind == ufe_pkg::KIND_BAD;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_root   = out_root_r;
  assign out_merged = out_merged_r;
  assign out_bad    = out_bad_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("table written and read at the same entry");

  a_post_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |=> out_valid_r)
    else $error("posted result not presented");

  a_link_roots: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.link |-> (root_a_r != root_b_r))
    else $error("link issued for one set");

  a_comp_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compress |-> (cur_r != cur_root))
    else $error("compression overwrote the root entry");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam logic [ufe_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int TABLE_SIZE = 1024;
  localparam int STALL_LIMIT = 6000;
  localparam int RANDOM_PER_PHASE = 188;

  typedef struct {
    logic [ufe_pkg::MODE_W-1:0] mode;
    logic [ufe_pkg::NODE_W-1:0] node_a;
    logic [ufe_pkg::NODE_W-1:0] node_b;
  } uf_op_t;

  typedef struct {
    logic [ufe_pkg::NODE_W-1:0] root;
    logic                       merged;
    logic                       bad_node;
  } uf_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // mode, node_a, node_b
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // root, merged, bad_node
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;

  union_find_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow copy of the disjoint-set table and the node count.
  logic [ufe_pkg::NODE_W-1:0]  link_tbl [TABLE_SIZE];
  logic [ufe_pkg::RANK_W-1:0]  rank_tbl [TABLE_SIZE];
  logic [ufe_pkg::COUNT_W-1:0] node_cnt;

  uf_op_t  op_q[$];
  uf_res_t root_q[$];
  uf_op_t  beat_op;

  int  n_queued, n_taken, n_checked, n_errors, idle_cycles;
  int  n_find, n_union, n_merge, n_bad, n_clear;
  bit  calm;

  int  phase_counts[8] = '{2, 1, 16, 100, 1024, 37, 2047, 1023};
  int  lim, r;
  uf_op_t rnd_op;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int valid_limit();
    return (node_cnt > TABLE_SIZE) ? TABLE_SIZE : int'(node_cnt);
  endfunction

  function automatic void clear_sets();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      link_tbl[i] = ufe_pkg::NODE_W'(i);
      rank_tbl[i] = ufe_pkg::RANK_RESET;
    end
  endfunction

  // Locate the root, then point every node on the path straight at it.
  function automatic logic [ufe_pkg::NODE_W-1:0] find_root(
    input logic [ufe_pkg::NODE_W-1:0] node
  );
    logic [ufe_pkg::NODE_W-1:0] top, cur, nxt;
    int n;
    top = node;
    n = 0;
    while (n < TABLE_SIZE && link_tbl[top] != top) begin
      top = link_tbl[top];
      n++;
    end
    cur = node;
    n = 0;
    while (n < TABLE_SIZE && cur != top) begin
      nxt = link_tbl[cur];
      link_tbl[cur] = top;
      cur = nxt;
      n++;
    end
    return top;
  endfunction

  function automatic uf_res_t apply_op(input uf_op_t op);
    uf_res_t res;
    logic [ufe_pkg::NODE_W-1:0] ra, rb;
    int lmt;
    res = '{root: '0, merged: 1'b0, bad_node: 1'b0};
    lmt = valid_limit();
    case (op.mode)
      ufe_pkg::MODE_CLEAR: begin
        clear_sets();
        n_clear++;
      end
      ufe_pkg::MODE_FIND: begin
        n_find++;
        if (op.node_a >= lmt) res.bad_node = 1'b1;
        else res.root = find_root(op.node_a);
      end
      ufe_pkg::MODE_UNION: begin
        n_union++;
        if (op.node_a >= lmt || op.node_b >= lmt) begin
          res.bad_node = 1'b1;
        end else begin
          ra = find_root(op.node_a);
          rb = find_root(op.node_b);
          if (ra == rb) begin
            res.root = ra;
          end else begin
            res.merged = 1'b1;
            if (rank_tbl[ra] > rank_tbl[rb]) begin
              link_tbl[rb] = ra;
              res.root = ra;
            end else begin
              // On a tie the root of node_a goes under the root of node_b.
              if (rank_tbl[ra] == rank_tbl[rb] && rank_tbl[rb] < ufe_pkg::RANK_MAX)
                rank_tbl[rb] = rank_tbl[rb] + 1'b1;
              link_tbl[ra] = rb;
              res.root = rb;
            end
          end
        end
      end
      default: ;
    endcase
    if (res.bad_node) n_bad++;
    if (res.merged) n_merge++;
    return res;
  endfunction

  function automatic logic [ufe_pkg::NODE_W-1:0] pick_node(input int lmt);
    if (lmt == 0 || $urandom_range(9) == 0)
      return ufe_pkg::NODE_W'($urandom_range(TABLE_SIZE - 1));
    return ufe_pkg::NODE_W'($urandom_range(lmt - 1));
  endfunction

  task automatic queue_op(input logic [ufe_pkg::MODE_W-1:0] mode, input int a, input int b);
    op_q.insert(op_q.size(),
                '{mode: mode, node_a: ufe_pkg::NODE_W'(a), node_b: ufe_pkg::NODE_W'(b)});
    n_queued++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (n_taken != n_queued || root_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_count(input int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ufe_pkg::COUNT_W'(value);
    node_cnt     = ufe_pkg::COUNT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Input driver: a beat stays up until it is taken.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      root_q.insert(root_q.size(), apply_op(beat_op));
      n_taken++;
    end
    if (!in_tvalid || in_tready) begin
      if (op_q.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
        beat_op = op_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, beat_op.node_b, beat_op.node_a, beat_op.mode};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    uf_res_t want;
    if (out_tvalid && out_tready) begin
      if (root_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat: %h", out_tdata);
      end else begin
        want = root_q.pop_front();
        n_checked++;
        if (out_tdata[9:0] !== want.root || out_tdata[10] !== want.merged ||
            out_tdata[11] !== want.bad_node) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"result %0d: expected root=%0d merged=%b bad=%b, ",
                      "got root=%0d merged=%b bad=%b"},
                     n_checked, want.root, want.merged, want.bad_node,
                     out_tdata[9:0], out_tdata[10], out_tdata[11]);
        end
      end
    end
    out_tready <= calm || ($urandom_range(99) >= 13);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b0;
    node_cnt    = ufe_pkg::COUNT_RESET;
    clear_sets();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Full table: extremes, ties, rank wins, path compression, spare mode.
    queue_op(ufe_pkg::MODE_FIND, 0, 0);
    queue_op(ufe_pkg::MODE_FIND, 1023, 1023);
    queue_op(ufe_pkg::MODE_UNION, 0, 1023);
    queue_op(ufe_pkg::MODE_UNION, 0, 1023);
    queue_op(ufe_pkg::MODE_UNION, 3, 900);
    queue_op(ufe_pkg::MODE_UNION, 5, 3);
    queue_op(ufe_pkg::MODE_FIND, 5, 0);
    queue_op(ufe_pkg::MODE_UNION, 10, 11);
    queue_op(ufe_pkg::MODE_UNION, 12, 13);
    queue_op(ufe_pkg::MODE_UNION, 11, 13);
    queue_op(ufe_pkg::MODE_FIND, 10, 0);
    queue_op(ufe_pkg::MODE_UNION, 1023, 1023);
    queue_op(MODE_SPARE, 1023, 1023);
    wait_idle();

    // Shrunk count: a link to a node above the count is still followed.
    write_count(16);
    queue_op(ufe_pkg::MODE_FIND, 3, 0);
    queue_op(ufe_pkg::MODE_FIND, 16, 0);
    queue_op(ufe_pkg::MODE_UNION, 15, 16);
    queue_op(ufe_pkg::MODE_UNION, 16, 0);
    queue_op(ufe_pkg::MODE_FIND, 15, 0);
    wait_idle();

    // Zero count rejects every index; clear still resets the whole table.
    write_count(0);
    queue_op(ufe_pkg::MODE_FIND, 0, 0);
    queue_op(ufe_pkg::MODE_UNION, 0, 0);
    queue_op(MODE_SPARE, 0, 0);
    queue_op(ufe_pkg::MODE_CLEAR, 1023, 1023);
    wait_idle();

    write_count(2047);
    queue_op(ufe_pkg::MODE_FIND, 1023, 0);
    queue_op(ufe_pkg::MODE_UNION, 1023, 0);
    wait_idle();

    // Random phases, mostly unions and finds on valid nodes so sets grow deep.
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      calm = (p == 4);
      lim = valid_limit();
      repeat (RANDOM_PER_PHASE) begin
        r = $urandom_range(999);
        rnd_op.mode = (r < 15) ? ufe_pkg::MODE_CLEAR : (r < 45) ? MODE_SPARE :
                      (r < 450) ? ufe_pkg::MODE_FIND : ufe_pkg::MODE_UNION;
        queue_op(rnd_op.mode, pick_node(lim), pick_node(lim));
      end
      wait_idle();
    end
    calm = 1'b0;

    repeat (50) @(negedge clk);
    if (root_q.size() != 0) begin
      $display("%0d expected results never arrived", root_q.size());
      n_errors += root_q.size();
    end
    $display("Checked %0d results: %0d finds, %0d unions (%0d merges), %0d clears,",
             n_checked, n_find, n_union, n_merge, n_clear);
    $display("%0d rejected indices, node counts from 0 to 2047.", n_bad);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
